/* sv/crt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the colour ramp table.
// No dependencies; imported by crt_blend and colour_ramp_table.
package crt_pkg;

  // Table geometry
  localparam int unsigned MaxStops = 16;
  localparam int unsigned IdxW     = $clog2(MaxStops);
  localparam int unsigned CntW     = $clog2(MaxStops + 1);

  // Field widths
  localparam int unsigned PosW  = 16;
  localparam int unsigned ColW  = 8;
  localparam int unsigned ProdW = PosW + ColW;
  localparam int unsigned StepW = $clog2(ColW);

  // Command codes
  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_NEAREST = 2'd2,
    CMD_INTERP  = 2'd3
  } cmd_e;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // One colour stop
  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [ColW-1:0] red;
    logic [ColW-1:0] green;
    logic [ColW-1:0] blue;
  } stop_t;

  // Operands of one channel blend
  typedef struct packed {
    logic [ColW-1:0] lo;
    logic [ColW-1:0] hi;
    logic [PosW-1:0] t;
    logic [PosW-1:0] span;
  } blend_req_t;

endpackage

/* sv/crt_blend.sv */
`timescale 1ns / 1ps
// One-channel linear blend: lo + floor((hi - lo) * t / span), truncated.
// A multiply step, then a restoring divider retiring one quotient bit a cycle.
// Depends on crt_pkg.
module crt_blend (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  crt_pkg::blend_req_t req_i,
  output logic                done_o,
  output logic [7:0]          result_o
);
  import crt_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_DONE} bstate_e;

  bstate_e          state_q;
  logic             neg_q;
  logic [ColW-1:0]  mag_q;
  logic [ColW-1:0]  lo_q;
  logic [PosW-1:0]  t_q;
  logic [PosW-1:0]  span_q;
  logic [ProdW-1:0] rem_q;
  logic [ColW-1:0]  quo_q;
  logic [StepW-1:0] step_q;

  logic [ProdW-1:0] trial;
  logic             fits;

  // Divisor aligned to the current quotient bit
  assign trial = ProdW'(span_q) << step_q;
  assign fits  = (rem_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      lo_q    <= '0;
      t_q     <= '0;
      span_q  <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (start_i) begin
            neg_q   <= (req_i.hi < req_i.lo);
            mag_q   <= (req_i.hi < req_i.lo) ? (req_i.lo - req_i.hi)
                                             : (req_i.hi - req_i.lo);
            lo_q    <= req_i.lo;
            t_q     <= req_i.t;
            span_q  <= req_i.span;
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          // |hi - lo| * t; quotient stays below 2^ColW since t <= span
          rem_q   <= ProdW'(mag_q) * ProdW'(t_q);
          quo_q   <= '0;
          step_q  <= StepW'(ColW - 1);
          state_q <= B_DIV;
        end
        B_DIV: begin
          if (fits) begin
            rem_q         <= rem_q - trial;
            quo_q[step_q] <= 1'b1;
          end
          if (step_q == '0) begin
            state_q <= B_DONE;
          end else begin
            step_q <= step_q - StepW'(1);
          end
        end
        B_DONE: begin
          state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // Negative slope rounds toward minus infinity: subtract the ceiling
  assign done_o   = (state_q == B_DONE);
  assign result_o = neg_q ? (lo_q - quo_q - ColW'(rem_q != '0)) : (lo_q + quo_q);

endmodule

/* sv/colour_ramp_table.sv */
`timescale 1ns / 1ps
// Colour ramp table: position-sorted colour stops with insert, remove, nearest, interpolate.
// Sequence: a scan of the stored stops in S_SCAN, then S_APPLY and S_FINISH for table commands;
// interpolate between two stops then adds three channel blends, one after another, in the
// shared multiply/divide unit. A request is taken only in S_IDLE, after the last one finishes.
// A finished result waits in the output register while the next request is accepted.
// Reset (rst_ni low, asynchronous) empties the table; stop contents are not cleared.
module colour_ramp_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position[15:0], red_in[23:16], green_in[31:24],
                                     // blue_in[39:32]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // red_out[7:0], green_out[15:8], blue_out[23:16],
                                     // position_out[39:24]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);
  import crt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_APPLY, S_BLEND_GO, S_BLEND_WAIT, S_FINISH
  } state_e;

  localparam logic [1:0] LastCh = 2'd2;

  state_e          state_q;
  cmd_e            cmd_q;
  stop_t           new_q;
  stop_t           cur_q;
  stop_t           prev_q;
  logic            hit_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] count_q;
  logic [1:0]      ch_q;
  stop_t           res_q;
  logic [1:0]      res_st_q;
  logic            m_valid_q;
  stop_t           out_q;
  logic [1:0]      out_st_q;

  stop_t           stops_q [MaxStops];

  logic            accept;
  logic            out_load;
  stop_t           in_stop;
  cmd_e            in_cmd;
  stop_t           scan_entry;
  logic            scan_found;
  logic            take_upper;
  logic [CntW-1:0] sel_idx;
  stop_t           sel_stop;
  blend_req_t      blend_req;
  logic            blend_done;
  logic [ColW-1:0] blend_res;

  // Input request unpacking
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_cmd        = cmd_e'(s_axis_tuser);
  assign in_stop.pos   = s_axis_tdata[15:0];
  assign in_stop.red   = s_axis_tdata[23:16];
  assign in_stop.green = s_axis_tdata[31:24];
  assign in_stop.blue  = s_axis_tdata[39:32];

  // Finished result moves to the output register when it is free or being taken
  assign out_load = (state_q == S_FINISH) && (!m_valid_q || m_axis_tready);

  // Scan compare: insert, remove and nearest look for strictly above, interpolate for at or above
  assign scan_entry = stops_q[idx_q[IdxW-1:0]];
  assign scan_found = (cmd_q == CMD_INTERP) ? (scan_entry.pos >= new_q.pos)
                                            : (scan_entry.pos >  new_q.pos);

  // Nearest pick; a tie keeps the earlier stop
  assign take_upper = (cur_q.pos - new_q.pos) < (new_q.pos - prev_q.pos);
  always_comb begin
    if (!hit_q) begin
      sel_idx  = idx_q - CntW'(1);
      sel_stop = prev_q;
    end else if (idx_q == '0 || take_upper) begin
      sel_idx  = idx_q;
      sel_stop = cur_q;
    end else begin
      sel_idx  = idx_q - CntW'(1);
      sel_stop = prev_q;
    end
  end

  // Blend operands for the current channel
  always_comb begin
    blend_req.t    = new_q.pos - prev_q.pos;
    blend_req.span = cur_q.pos - prev_q.pos;
    unique case (ch_q)
      2'd0: begin
        blend_req.lo = prev_q.red;
        blend_req.hi = cur_q.red;
      end
      2'd1: begin
        blend_req.lo = prev_q.green;
        blend_req.hi = cur_q.green;
      end
      default: begin
        blend_req.lo = prev_q.blue;
        blend_req.hi = cur_q.blue;
      end
    endcase
  end

  crt_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == S_BLEND_GO),
    .req_i    (blend_req),
    .done_o   (blend_done),
    .result_o (blend_res)
  );

  // Stop storage: each entry shifts from a fixed neighbor on insert or remove
  for (genvar m = 0; m < MaxStops; m++) begin : g_stop
    always_ff @(posedge clk_i) begin
      if (state_q == S_APPLY && cmd_q == CMD_INSERT) begin
        if (CntW'(m) == idx_q) begin
          stops_q[m] <= new_q;
        end else if (m > 0 && CntW'(m) > idx_q && CntW'(m) <= count_q) begin
          stops_q[m] <= stops_q[(m > 0) ? m - 1 : 0];
        end
      end else if (state_q == S_APPLY && cmd_q == CMD_REMOVE) begin
        if (m < MaxStops - 1 && CntW'(m) >= sel_idx && CntW'(m + 1) < count_q) begin
          stops_q[m] <= stops_q[(m < MaxStops - 1) ? m + 1 : m];
        end
      end
    end
  end : g_stop

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmd_q     <= CMD_INSERT;
      new_q     <= '0;
      cur_q     <= '0;
      prev_q    <= '0;
      hit_q     <= 1'b0;
      idx_q     <= '0;
      count_q   <= '0;
      ch_q      <= '0;
      res_q     <= '0;
      res_st_q  <= STATUS_OK;
      m_valid_q <= 1'b0;
      out_q     <= '0;
      out_st_q  <= STATUS_OK;
    end else begin
      // Output register: load a finished result, drop the held one once taken
      if (out_load) begin
        out_q     <= res_q;
        out_st_q  <= res_st_q;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= in_cmd;
            new_q <= in_stop;
            idx_q <= '0;
            hit_q <= 1'b0;
            if (in_cmd == CMD_INSERT && count_q >= CntW'(MaxStops)) begin
              res_q    <= in_stop;
              res_st_q <= STATUS_FULL;
              state_q  <= S_FINISH;
            end else if (in_cmd != CMD_INSERT && count_q == '0) begin
              res_q    <= '0;
              res_st_q <= STATUS_EMPTY;
              state_q  <= S_FINISH;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx_q == count_q) begin
            state_q <= S_APPLY;
          end else if (scan_found) begin
            cur_q   <= scan_entry;
            hit_q   <= 1'b1;
            state_q <= S_APPLY;
          end else begin
            prev_q <= scan_entry;
            idx_q  <= idx_q + CntW'(1);
          end
        end
        S_APPLY: begin
          res_st_q <= STATUS_OK;
          unique case (cmd_q)
            CMD_INSERT: begin
              count_q <= count_q + CntW'(1);
              res_q   <= new_q;
              state_q <= S_FINISH;
            end
            CMD_REMOVE, CMD_NEAREST: begin
              if (cmd_q == CMD_REMOVE) begin
                count_q <= count_q - CntW'(1);
              end
              res_q   <= sel_stop;
              state_q <= S_FINISH;
            end
            default: begin
              if (!hit_q) begin
                res_q   <= prev_q;
                state_q <= S_FINISH;
              end else if (idx_q == '0) begin
                res_q   <= cur_q;
                state_q <= S_FINISH;
              end else begin
                res_q.pos <= new_q.pos;
                ch_q      <= '0;
                state_q   <= S_BLEND_GO;
              end
            end
          endcase
        end
        S_BLEND_GO: begin
          state_q <= S_BLEND_WAIT;
        end
        S_BLEND_WAIT: begin
          if (blend_done) begin
            unique case (ch_q)
              2'd0:    res_q.red   <= blend_res;
              2'd1:    res_q.green <= blend_res;
              default: res_q.blue  <= blend_res;
            endcase
            if (ch_q == LastCh) begin
              state_q <= S_FINISH;
            end else begin
              ch_q    <= ch_q + 2'd1;
              state_q <= S_BLEND_GO;
            end
          end
        end
        S_FINISH: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Output packing
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_q.pos, out_q.blue, out_q.green, out_q.red};
  assign m_axis_tuser  = out_st_q;

endmodule
